/* design/assert_macros.svh */
// Shared assertion shorthands. Both expect signals named clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

/* design/kron_pkg.sv */
package kron_pkg;

  // Operand widths
  localparam int IN_W  = 32;
  localparam int OPW   = 32;
  localparam int CNT_W = $clog2(OPW + 1);
  localparam int PC_W  = 4;

  // Symbol encodings, two's complement
  localparam logic [1:0] SYM_ZERO = 2'b00;
  localparam logic [1:0] SYM_POS  = 2'b01;
  localparam logic [1:0] SYM_NEG  = 2'b11;

  // (2/n) sign by n mod 8
  localparam logic signed [1:0] TWO_SIGN [8] = '{
    2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd0, -2'sd1, 2'sd0, 2'sd1
  };

  // Datapath operations
  localparam logic [3:0] OP_NOP       = 4'd0;
  localparam logic [3:0] OP_LOAD      = 4'd1;
  localparam logic [3:0] OP_TRIVIAL   = 4'd2;
  localparam logic [3:0] OP_ZERO      = 4'd3;
  localparam logic [3:0] OP_HALVE_B   = 4'd4;
  localparam logic [3:0] OP_SIGN_2A   = 4'd5;
  localparam logic [3:0] OP_SET_RES   = 4'd6;
  localparam logic [3:0] OP_HALVE_A   = 4'd7;
  localparam logic [3:0] OP_SIGN_LOOP = 4'd8;
  localparam logic [3:0] OP_MOD_INIT  = 4'd9;
  localparam logic [3:0] OP_MOD_STEP  = 4'd10;
  localparam logic [3:0] OP_SWAP      = 4'd11;
  localparam logic [3:0] OP_EMIT      = 4'd12;

  // Branch conditions
  localparam logic [3:0] C_ALWAYS    = 4'd0;
  localparam logic [3:0] C_ACCEPT    = 4'd1;
  localparam logic [3:0] C_ANY_ZERO  = 4'd2;
  localparam logic [3:0] C_BOTH_EVEN = 4'd3;
  localparam logic [3:0] C_B_EVEN    = 4'd4;
  localparam logic [3:0] C_A_ZERO    = 4'd5;
  localparam logic [3:0] C_A_EVEN    = 4'd6;
  localparam logic [3:0] C_MOD_MORE  = 4'd7;
  localparam logic [3:0] C_OUT_FREE  = 4'd8;

  // Program addresses
  localparam logic [PC_W-1:0] S_IDLE      = 4'd0;
  localparam logic [PC_W-1:0] S_CHK_ZERO  = 4'd1;
  localparam logic [PC_W-1:0] S_CHK_EVEN  = 4'd2;
  localparam logic [PC_W-1:0] S_STRIP_B   = 4'd3;
  localparam logic [PC_W-1:0] S_SIGN_2A   = 4'd4;
  localparam logic [PC_W-1:0] S_LOOP      = 4'd5;
  localparam logic [PC_W-1:0] S_STRIP_A   = 4'd6;
  localparam logic [PC_W-1:0] S_SIGN_LOOP = 4'd7;
  localparam logic [PC_W-1:0] S_MOD_INIT  = 4'd8;
  localparam logic [PC_W-1:0] S_MOD_STEP  = 4'd9;
  localparam logic [PC_W-1:0] S_SWAP      = 4'd10;
  localparam logic [PC_W-1:0] S_FIN       = 4'd11;

  // Control word: op runs only when cond holds, then branch to nxt_t, else nxt_f
  typedef struct packed {
    logic [3:0]      op;
    logic [3:0]      cond;
    logic [PC_W-1:0] nxt_t;
    logic [PC_W-1:0] nxt_f;
  } uword_t;

  typedef struct packed {
    logic [3:0] op;
    logic       en;
  } dp_ctrl_t;

  typedef struct packed {
    logic any_zero;
    logic both_even;
    logic a_even;
    logic b_even;
    logic a_zero;
    logic mod_more;
  } dp_flags_t;

  // Microprogram ROM
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      S_IDLE:      w = '{OP_LOAD,      C_ACCEPT,    S_CHK_ZERO,  S_IDLE};
      S_CHK_ZERO:  w = '{OP_TRIVIAL,   C_ANY_ZERO,  S_FIN,       S_CHK_EVEN};
      S_CHK_EVEN:  w = '{OP_ZERO,      C_BOTH_EVEN, S_FIN,       S_STRIP_B};
      S_STRIP_B:   w = '{OP_HALVE_B,   C_B_EVEN,    S_STRIP_B,   S_SIGN_2A};
      S_SIGN_2A:   w = '{OP_SIGN_2A,   C_ALWAYS,    S_LOOP,      S_LOOP};
      S_LOOP:      w = '{OP_SET_RES,   C_A_ZERO,    S_FIN,       S_STRIP_A};
      S_STRIP_A:   w = '{OP_HALVE_A,   C_A_EVEN,    S_STRIP_A,   S_SIGN_LOOP};
      S_SIGN_LOOP: w = '{OP_SIGN_LOOP, C_ALWAYS,    S_MOD_INIT,  S_MOD_INIT};
      S_MOD_INIT:  w = '{OP_MOD_INIT,  C_ALWAYS,    S_MOD_STEP,  S_MOD_STEP};
      S_MOD_STEP:  w = '{OP_MOD_STEP,  C_MOD_MORE,  S_MOD_STEP,  S_SWAP};
      S_SWAP:      w = '{OP_SWAP,      C_ALWAYS,    S_LOOP,      S_LOOP};
      S_FIN:       w = '{OP_EMIT,      C_OUT_FREE,  S_IDLE,      S_FIN};
      default:     w = '{OP_NOP,       C_ALWAYS,    S_IDLE,      S_IDLE};
    endcase
    return w;
  endfunction

  // True where (2/n) is -1
  function automatic logic two_neg(input logic [2:0] r);
    return TWO_SIGN[r] == -2'sd1;
  endfunction

endpackage

/* design/kron_datapath.sv */
module kron_datapath
  import kron_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  dp_ctrl_t         ctrl,
  input  logic [IN_W-1:0]  in_a_value,
  input  logic [IN_W-1:0]  in_b_value,
  output dp_flags_t        flags,
  output logic [1:0]       res
);

  logic [OPW-1:0]   a_r, a_nxt;
  logic [OPW-1:0]   b_r, b_nxt;
  logic [OPW-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             par_r, par_nxt;
  logic             neg_r, neg_nxt;
  logic [1:0]       res_r, res_nxt;

  // One restoring step of b mod a; b doubles as the dividend shift register
  logic [OPW:0] shl;
  logic [OPW:0] diff;
  assign shl  = {rem_r, b_r[OPW-1]};
  assign diff = shl - {1'b0, a_r};

  // Status back to the sequencer
  assign flags.any_zero  = (a_r == '0) || (b_r == '0);
  assign flags.both_even = !a_r[0] && !b_r[0];
  assign flags.a_even    = !a_r[0];
  assign flags.b_even    = !b_r[0];
  assign flags.a_zero    = (a_r == '0);
  assign flags.mod_more  = (cnt_r != '0);
  assign res             = res_r;

  // Operation decode
  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    par_nxt = par_r;
    neg_nxt = neg_r;
    res_nxt = res_r;
    if (ctrl.en) begin
      unique case (ctrl.op)
        OP_LOAD: begin
          a_nxt   = OPW'(in_a_value);
          b_nxt   = OPW'(in_b_value);
          par_nxt = 1'b0;
          neg_nxt = 1'b0;
        end
        OP_TRIVIAL: res_nxt = ((a_r | b_r) == OPW'(1)) ? SYM_POS : SYM_ZERO;
        OP_ZERO:    res_nxt = SYM_ZERO;
        OP_HALVE_B: begin
          b_nxt   = b_r >> 1;
          par_nxt = !par_r;
        end
        OP_SIGN_2A: begin
          neg_nxt = neg_r ^ (par_r && two_neg(a_r[2:0]));
          par_nxt = 1'b0;
        end
        OP_SET_RES: begin
          if (b_r == OPW'(1)) res_nxt = neg_r ? SYM_NEG : SYM_POS;
          else                res_nxt = SYM_ZERO;
        end
        OP_HALVE_A: begin
          a_nxt   = a_r >> 1;
          par_nxt = !par_r;
        end
        OP_SIGN_LOOP: begin
          // (2/b) for an odd count of twos, then reciprocity flip
          neg_nxt = neg_r ^ (par_r && two_neg(b_r[2:0])) ^ (a_r[1] && b_r[1]);
          par_nxt = 1'b0;
        end
        OP_MOD_INIT: begin
          rem_nxt = '0;
          cnt_nxt = CNT_W'(OPW);
        end
        OP_MOD_STEP: begin
          rem_nxt = diff[OPW] ? shl[OPW-1:0] : diff[OPW-1:0];
          b_nxt   = b_r << 1;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
        OP_SWAP: begin
          b_nxt = a_r;
          a_nxt = rem_r;
        end
        default: ;
      endcase
    end
  end

  // Working registers, payload only
  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    par_r <= par_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

`include "assert_macros.svh"

  // Partial remainder always reduced below the divisor
  `ASSERT_NEXT(a_rem_reduced, ctrl.en && ctrl.op == OP_MOD_STEP, rem_r < a_r)
  // b is odd whenever the loop applies its sign rules
  `ASSERT_IMPL(a_b_odd_in_loop, ctrl.en && ctrl.op == OP_SIGN_LOOP, b_r[0])

endmodule

/* design/kronecker_symbol.sv */
// Kronecker symbol unit: out_symbol = (a/b) as -1 (2'b11), 0 or +1.
// Input channel: in_valid/in_stall with in_a_value, in_b_value, both unsigned.
// Result channel: out_valid/out_stall with out_symbol; one result per operand pair.
// A transfer happens on a rising edge with valid high and stall low.
// A small microprogram steps a plain datapath: zero and even checks, stripping
// twos from b, then Euclid rounds of (strip twos from a, sign fix, b mod a, swap).
// The remainder is a bit-serial restoring divider, one bit per cycle. Trivial
// cases (a zero operand, both even) skip the Euclid rounds and go straight
// to the final step. One item is in work at a time: in_stall is low only
// while the sequencer waits at its idle step.
// The result sits in an output register, so a new pair may be taken while the
// last result still waits; the sequencer only holds at its final step if the
// receiver is stalling with an older result unread.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops out_valid.
module kronecker_symbol
  import kron_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [IN_W-1:0] in_a_value,
  input  logic [IN_W-1:0] in_b_value,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      out_symbol
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_symbol_r, out_symbol_nxt;

  uword_t    uw;
  dp_ctrl_t  ctrl;
  dp_flags_t flags;
  logic [1:0] res;
  logic      in_xfer;
  logic      out_free;
  logic      hit;

  assign in_stall = (pc_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Fetch and condition select
  assign uw = ucode(pc_r);

  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:    hit = 1'b1;
      C_ACCEPT:    hit = in_xfer;
      C_ANY_ZERO:  hit = flags.any_zero;
      C_BOTH_EVEN: hit = flags.both_even;
      C_B_EVEN:    hit = flags.b_even;
      C_A_ZERO:    hit = flags.a_zero;
      C_A_EVEN:    hit = flags.a_even;
      C_MOD_MORE:  hit = flags.mod_more;
      C_OUT_FREE:  hit = out_free;
      default:     hit = 1'b0;
    endcase
  end

  assign ctrl.op = uw.op;
  assign ctrl.en = hit;
  assign pc_nxt  = hit ? uw.nxt_t : uw.nxt_f;

  kron_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .in_a_value (in_a_value),
    .in_b_value (in_b_value),
    .flags      (flags),
    .res        (res)
  );

  // Output register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_symbol_nxt = out_symbol_r;
    if (ctrl.en && ctrl.op == OP_EMIT) begin
      out_valid_nxt  = 1'b1;
      out_symbol_nxt = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_symbol_r <= out_symbol_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;

`include "assert_macros.svh"

  // An accepted pair goes straight to the zero check
  `ASSERT_NEXT(a_load_next, in_xfer, pc_r == S_CHK_ZERO)
  // Only the three legal symbol codes leave the block
  `ASSERT_IMPL(a_sym_code, out_valid,
    out_symbol == SYM_ZERO || out_symbol == SYM_POS || out_symbol == SYM_NEG)

endmodule
